// ===== hw/rtl/lbtl_pkg.sv =====
`default_nettype none

package lbtl_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned COL_W  = 33;
   localparam int unsigned STAT_W = 2;

   // Configuration register indexes.
   localparam logic CSR_BASE_OFFSET = 1'b0;
   localparam logic CSR_TEXT_LENGTH = 1'b1;

   // Input operations.
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_LOCATE = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_BELOW_BASE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH_PREV,
      ST_FINISH
   } lbtl_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/line_break_table_locator_top.sv =====
`default_nettype none

// Line break table locator. An append transfer (operation 0) stores position minus
// base_offset as the next line break and answers with a status only. A locate
// transfer (operation 1) bisects the stored breaks, one probe per cycle through the
// single read port of the break table memory, and then reads the line's end break
// and the previous break. One item is in work at a time; the result register lets
// the next item be taken while a result still waits, and that item then holds in its
// last cycle until the waiting result is taken.
// The table needs no clearing after reset, since only entries below the break count
// are ever used.
module line_break_table_locator_top
   import lbtl_pkg::*;
#(
   parameter int unsigned MAX_BREAKS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic                              csr_index,
   input  wire logic [DATA_W-1:0]                 csr_data,
   input  wire logic                              req_valid,
   output      logic                              req_ready,
   input  wire logic                              req_operation,
   input  wire logic [DATA_W-1:0]                 req_position,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [$clog2(MAX_BREAKS+2)-1:0]   rsp_line_number,
   output      logic [COL_W-1:0]                  rsp_column_number,
   output      logic [DATA_W-1:0]                 rsp_line_start,
   output      logic [DATA_W-1:0]                 rsp_line_end,
   output      logic [STAT_W-1:0]                 rsp_status
);

   localparam int unsigned AW = $clog2(MAX_BREAKS);
   localparam int unsigned CW = $clog2(MAX_BREAKS + 1);
   localparam int unsigned LW = $clog2(MAX_BREAKS + 2);

   lbtl_state_type state_ff, state_in;

   logic [DATA_W-1:0] base_ff, tlen_ff;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [DATA_W-1:0] pos_ff, pos_in;
   logic              op_ff, op_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] end_ff, end_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]     line_ff, line_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [DATA_W-1:0] start_ff, start_in;
   logic [DATA_W-1:0] lend_ff, lend_in;
   logic [STAT_W-1:0] rstat_ff, rstat_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              req_fire, out_free;
   logic              go_right;
   logic [CW-1:0]     lo_step, hi_step, mid_step;

   lbtl_break_ram #(
      .DEPTH(MAX_BREAKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // One bisection step on the entry read for the current midpoint.
   assign go_right = (ram_rdata < pos_ff);
   assign lo_step  = go_right ? CW'(mid_ff) + CW'(1) : lo_ff;
   assign hi_step  = go_right ? hi_ff : CW'(mid_ff);
   assign mid_step = lo_step + ((hi_step - lo_step) >> 1);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == OP_LOCATE && count_ff != '0) begin
                  state_in = ST_SEARCH;
               end else if (req_operation == OP_LOCATE) begin
                  state_in = ST_FETCH_PREV;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SEARCH: begin
            if (lo_step >= hi_step) begin
               state_in = ST_FETCH_PREV;
            end
         end
         ST_FETCH_PREV: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pos_in       = pos_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      line_in      = line_ff;
      col_in       = col_ff;
      start_in     = start_ff;
      lend_in      = lend_ff;
      rstat_in     = rstat_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = req_position - base_ff;
      ram_re       = 1'b0;
      ram_raddr    = mid_step[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pos_in    = req_position;
               op_in     = req_operation;
               status_in = STATUS_OK;
               lo_in     = '0;
               hi_in     = count_ff;
               mid_in    = AW'(count_ff >> 1);
               ram_re    = (req_operation == OP_LOCATE);
               ram_raddr = AW'(count_ff >> 1);
               if (req_operation == OP_APPEND) begin
                  if (count_ff == CW'(MAX_BREAKS)) begin
                     status_in = STATUS_FULL;
                  end else if (req_position < base_ff) begin
                     status_in = STATUS_BELOW_BASE;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
         end
         ST_SEARCH: begin
            lo_in  = lo_step;
            hi_in  = hi_step;
            mid_in = mid_step[AW-1:0];
            ram_re = 1'b1;
            // When the bisection closes, fetch the break that ends the line.
            if (lo_step >= hi_step) begin
               ram_raddr = lo_step[AW-1:0];
            end
         end
         ST_FETCH_PREV: begin
            end_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = lo_ff[AW-1:0] - AW'(1);
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_APPEND) begin
                  line_in  = '0;
                  col_in   = '0;
                  start_in = '0;
                  lend_in  = '0;
                  rstat_in = status_ff;
               end else begin
                  line_in  = LW'(lo_ff) + LW'(1);
                  rstat_in = STATUS_OK;
                  if (lo_ff == '0) begin
                     col_in   = COL_W'(pos_ff) + COL_W'(1);
                     start_in = '0;
                  end else begin
                     col_in   = COL_W'(pos_ff - ram_rdata);
                     start_in = ram_rdata + DATA_W'(1);
                  end
                  lend_in = (lo_ff < count_ff) ? end_ff : tlen_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         tlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_OFFSET: base_ff <= csr_data;
               CSR_TEXT_LENGTH: tlen_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      end_ff    <= end_in;
      line_ff   <= line_in;
      col_ff    <= col_in;
      start_ff  <= start_in;
      lend_ff   <= lend_in;
      rstat_ff  <= rstat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_number   = line_ff;
   assign rsp_column_number = col_ff;
   assign rsp_line_start    = start_ff;
   assign rsp_line_end      = lend_ff;
   assign rsp_status        = rstat_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lbtl_break_ram.sv =====
`default_nettype none

// Break table storage: one write port, one read port, registered read data.
module lbtl_break_ram
   import lbtl_pkg::*;
#(
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]          wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output      logic [DATA_W-1:0]          rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lbtl_checker.sv =====
`default_nettype none

module lbtl_checker
   import lbtl_pkg::*;
#(
   parameter int unsigned MAX_BREAKS = 1024
) (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [$clog2(MAX_BREAKS+2)-1:0]   rsp_line_number,
   input wire logic [COL_W-1:0]                  rsp_column_number,
   input wire logic [DATA_W-1:0]                 rsp_line_start,
   input wire logic [STAT_W-1:0]                 rsp_status
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A dropped append carries no line or column.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_line_number == '0
         && rsp_column_number == '0)
      else $error("dropped append reports a location");

   // A locate result always reports success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_number != '0 |-> rsp_status == STATUS_OK)
      else $error("locate result with nonzero status");

   // The first line starts at offset zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_number == 1 |-> rsp_line_start == '0)
      else $error("first line does not start at zero");

   // Only a first-line column can reach past 32 bits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_number > 1 |-> !rsp_column_number[COL_W-1])
      else $error("column overflow on a later line");

endmodule

bind line_break_table_locator_top lbtl_checker #(
   .MAX_BREAKS(MAX_BREAKS)
) u_lbtl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_line_number   (rsp_line_number),
   .rsp_column_number (rsp_column_number),
   .rsp_line_start    (rsp_line_start),
   .rsp_status        (rsp_status)
);

`default_nettype wire
